[rtl/core/asfr_pkg.sv]
`timescale 1ns / 1ps

package asfr_pkg;

	localparam int NUM_CHAN     = 4;
	localparam int ADDR_W       = 6;
	localparam int CFG_IDX_W    = 2;
	localparam int MAX_PAYLOAD  = 16384;
	localparam int HEADER_BYTES = 4;
	localparam int POS_W        = 15;
	localparam int LEN_W        = 16;

	localparam logic [7:0] BCAST_DEST = 8'hFF;

	// Header byte positions
	localparam logic [POS_W-1:0] POS_DEST   = POS_W'(0);
	localparam logic [POS_W-1:0] POS_LEN_HI = POS_W'(2);
	localparam logic [POS_W-1:0] POS_LEN_LO = POS_W'(3);

	typedef logic [ADDR_W-1:0] addr_t;

	localparam addr_t CHAN_RESET [NUM_CHAN] = '{
		ADDR_W'(2), ADDR_W'(6), ADDR_W'(7), ADDR_W'(8)
	};

	typedef enum logic [2:0] {
		ST_BUSY     = 3'd0,
		ST_ACCEPT   = 3'd1,
		ST_BCAST    = 3'd2,
		ST_BADSUM   = 3'd3,
		ST_NOADDR   = 3'd4,
		ST_OVERSIZE = 3'd5
	} status_t;

	typedef struct packed {
		logic [7:0]       data;
		logic [POS_W-1:0] position;
		logic             frame_end;
		status_t          status;
		logic [1:0]       channel;
		logic [LEN_W-1:0] payload_length;
	} result_t;

endpackage

[rtl/core/addressed_serial_frame_receiver.sv]
`timescale 1ns / 1ps

// Frame receiver for an addressed serial bus: takes one received byte per
// cycle and returns one result per byte, the byte echoed with its position
// in the frame (destination, command, 16-bit big-endian length, payload,
// checksum). The byte at position length+4 closes the frame with its
// outcome: accepted on a channel, broadcast, bad checksum or not addressed;
// a length above 16384 closes it at the low length byte as oversized. Each
// byte passes an input register and a result register before its result is
// presented; a new byte is taken every cycle while the output side keeps up.
// Channel addresses must be written through cfg_we/cfg_index/cfg_data only
// while no frame byte is in flight; the block itself does not enforce this.
module addressed_serial_frame_receiver (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [asfr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [asfr_pkg::ADDR_W-1:0]     cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [7:0]                      rx_byte,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [7:0]                      byte_out,
	output logic [asfr_pkg::POS_W-1:0]      position,
	output logic                            frame_end,
	output logic [2:0]                      status,
	output logic [1:0]                      channel,
	output logic [asfr_pkg::LEN_W-1:0]      payload_length
);
	import asfr_pkg::*;

	addr_t      chan_addr [NUM_CHAN];
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       valid_s2;
	result_t    result_s2;
	result_t    result;
	logic       advance;
	logic       step;

	assign advance  = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign step     = valid_s1 && advance;

	asfr_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.chan_addr (chan_addr)
	);

	asfr_frame u_frame (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.data      (byte_s1),
		.chan_addr (chan_addr),
		.result    (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	// hold the result while the output side stalls
	always_ff @(posedge clk) begin
		if (step) begin
			result_s2 <= result;
		end
	end

	assign out_valid      = valid_s2;
	assign byte_out       = result_s2.data;
	assign position       = result_s2.position;
	assign frame_end      = result_s2.frame_end;
	assign status         = 3'(result_s2.status);
	assign channel        = result_s2.channel;
	assign payload_length = result_s2.payload_length;

endmodule

[rtl/core/asfr_cfg.sv]
`timescale 1ns / 1ps

module asfr_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [asfr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  asfr_pkg::addr_t                  cfg_data,
	output asfr_pkg::addr_t                  chan_addr [asfr_pkg::NUM_CHAN]
);
	import asfr_pkg::*;

	addr_t chan_addr_q [NUM_CHAN];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CHAN; i++) begin
				chan_addr_q[i] <= CHAN_RESET[i];
			end
		end else if (cfg_we) begin
			for (int i = 0; i < NUM_CHAN; i++) begin
				if (cfg_index == CFG_IDX_W'(i)) begin
					chan_addr_q[i] <= cfg_data;
				end
			end
		end
	end

	assign chan_addr = chan_addr_q;

endmodule

[rtl/core/asfr_frame.sv]
`timescale 1ns / 1ps

module asfr_frame (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic [7:0]         data,
	input  asfr_pkg::addr_t    chan_addr [asfr_pkg::NUM_CHAN],
	output asfr_pkg::result_t  result
);
	import asfr_pkg::*;

	logic [POS_W-1:0] byte_count_q;
	logic [7:0]       running_sum_q;
	logic [7:0]       dest_byte_q;
	logic [LEN_W-1:0] length_field_q;

	logic [7:0]       sum_next;
	logic [7:0]       dest_next;
	logic [LEN_W-1:0] len_next;
	logic [LEN_W:0]   end_pos;
	logic             oversize;
	logic             last;
	logic             done;
	logic             matched;
	logic [1:0]       match_chan;
	status_t          st;

	always_comb begin
		sum_next  = running_sum_q + data;
		dest_next = (byte_count_q == POS_DEST) ? data : dest_byte_q;
		len_next  = length_field_q;
		if (byte_count_q == POS_LEN_HI) begin
			len_next = {data, 8'h00};
		end else if (byte_count_q == POS_LEN_LO) begin
			len_next = {length_field_q[LEN_W-1:8], data};
		end
		end_pos  = {1'b0, len_next} + (LEN_W+1)'(HEADER_BYTES);
		oversize = (byte_count_q == POS_LEN_LO) && (len_next > LEN_W'(MAX_PAYLOAD));
		last     = (byte_count_q >= POS_W'(HEADER_BYTES))
			&& ((LEN_W+1)'(byte_count_q) == end_pos);
		done     = oversize || last;
	end

	// lowest matching channel wins
	always_comb begin
		matched    = 1'b0;
		match_chan = 2'd0;
		for (int i = NUM_CHAN - 1; i >= 0; i--) begin
			if (dest_next == 8'(chan_addr[i])) begin
				matched    = 1'b1;
				match_chan = 2'(i);
			end
		end
	end

	always_comb begin
		st = ST_BUSY;
		if (oversize) begin
			st = ST_OVERSIZE;
		end else if (last) begin
			if (sum_next != 8'h00) begin
				st = ST_BADSUM;
			end else if (dest_next == BCAST_DEST) begin
				st = ST_BCAST;
			end else if (matched) begin
				st = ST_ACCEPT;
			end else begin
				st = ST_NOADDR;
			end
		end
	end

	always_comb begin
		result.data           = data;
		result.position       = byte_count_q;
		result.frame_end      = done;
		result.status         = st;
		result.channel        = (st == ST_ACCEPT) ? match_chan : 2'd0;
		result.payload_length = len_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q   <= '0;
			running_sum_q  <= '0;
			dest_byte_q    <= '0;
			length_field_q <= '0;
		end else if (step) begin
			if (done) begin
				byte_count_q   <= '0;
				running_sum_q  <= '0;
				dest_byte_q    <= '0;
				length_field_q <= '0;
			end else begin
				byte_count_q   <= byte_count_q + POS_W'(1);
				running_sum_q  <= sum_next;
				dest_byte_q    <= dest_next;
				length_field_q <= len_next;
			end
		end
	end

endmodule
